[rtl/core/cil_pkg.sv]
// Package for the cursor image loader: sizes, format codes, the payload
// status struct shared by the intake and row engine, and a bit-reverse helper.
// Depends on nothing.
package cil_pkg;

  localparam int CURSOR_SIZE = 32;
  localparam int MAX_BYTES   = 1024;
  localparam int ADDR_W      = $clog2(MAX_BYTES);
  localparam int CNT_W       = $clog2(MAX_BYTES + 1);
  localparam int HDR_BYTES   = 16;
  localparam int HDR_W       = $clog2(HDR_BYTES);
  localparam int ROW_BYTES   = CURSOR_SIZE / 8;
  localparam int WB_W        = $clog2(ROW_BYTES + 1);
  localparam int ROWS_W      = $clog2(CURSOR_SIZE + 1);
  localparam int FIXED_MIN   = 2 * 4 + 2 * 2 * 16;
  localparam int FIXED_ROWS  = 16;
  localparam int FIXED_BPL   = 2;
  localparam int FIXED_CLR   = 8;
  localparam int FIXED_SET   = FIXED_CLR + FIXED_BPL * FIXED_ROWS;

  localparam logic [1:0] FMT_CLEAR = 2'd0;
  localparam logic [1:0] FMT_SIZED = 2'd1;
  localparam logic [1:0] FMT_FIXED = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
    logic [31:0]      hot_x;
    logic [31:0]      hot_y;
    logic [31:0]      width;
    logic [31:0]      height;
  } cil_pay_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[7-k] = b[k];
    return r;
  endfunction

endpackage

[rtl/core/cursor_image_loader.sv]
// Cursor image loader top level: payload RAM, byte intake and row engine.
// Depends on cil_pkg, cil_ram, cil_collect and cil_rows.
//
// Usage: payload bytes of one cursor write arrive on the in_ channel, one
// transfer per cycle while in_ready is high; in_last_byte marks the final byte.
// Bytes are stored in a 1024-entry payload RAM; bytes past its end are dropped
// and flag an overflow. After the last byte the block drops in_ready and
// decodes: it checks the header in a check and a setup state (sized format
// first, then the fixed 16x16 format, else a cleared cursor), then gives one
// result per visible row on the out_ channel, each shown until its transfer. A
// row reads one clear and one set byte for each of its w visible bytes (at
// most 4) through the single read port, then passes a drain state and the
// output state. With no visible bytes there are no reads and no drain: each
// row goes straight to the output state. A cursor with no rows gives a single
// result.
// When the receiver stalls, the result register simply holds. in_ready rises
// again in the cycle after the transfer of the result marked out_final_row.
// Reset (synchronous, active low) empties the byte count and overflow flag and
// returns to accepting bytes; RAM contents are not cleared.
module cursor_image_loader import cil_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_row_index,
  output logic [31:0]        out_source_bits,
  output logic [31:0]        out_mask_bits,
  output logic [5:0]         out_cursor_width,
  output logic [5:0]         out_cursor_height,
  output logic signed [31:0] out_hot_x,
  output logic signed [31:0] out_hot_y,
  output logic [1:0]         out_format_used,
  output logic               out_final_row
);

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              start, idle, clear;
  cil_pay_t          pay;

  // Bytes are taken only while the row engine has nothing in flight.
  assign in_ready = idle;

  cil_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cil_collect u_collect (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .take_en      (idle),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .clear        (clear),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .start        (start),
    .pay          (pay)
  );

  // The engine only reads entries below the byte count, so the RAM needs no
  // clearing after reset.
  cil_rows u_rows (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .pay               (pay),
    .ram_rdata         (ram_rdata),
    .ram_raddr         (ram_raddr),
    .idle              (idle),
    .clear             (clear),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_row_index     (out_row_index),
    .out_source_bits   (out_source_bits),
    .out_mask_bits     (out_mask_bits),
    .out_cursor_width  (out_cursor_width),
    .out_cursor_height (out_cursor_height),
    .out_hot_x         (out_hot_x),
    .out_hot_y         (out_hot_y),
    .out_format_used   (out_format_used),
    .out_final_row     (out_final_row)
  );

endmodule

[rtl/core/cil_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module cil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/cil_collect.sv]
// Byte intake for the cursor image loader: write pointer, overflow flag,
// header capture and payload RAM write port. Depends on cil_pkg.
module cil_collect import cil_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              take_en,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic              clear,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [7:0]        ram_wdata,
  output logic              start,
  output cil_pay_t          pay
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [7:0]       hdr_r [HDR_BYTES];
  logic             acc;
  logic             room;

  assign acc   = in_valid && take_en;
  assign room  = cnt_r < CNT_W'(MAX_BYTES);
  assign start = acc && in_last_byte;

  assign ram_we    = acc && room;
  assign ram_waddr = cnt_r[ADDR_W-1:0];
  assign ram_wdata = in_data_byte;

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (clear) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (acc) begin
      if (room) cnt_nxt = cnt_r + CNT_W'(1);
      else      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // Header bytes are kept in flops as well so the decode can see them at once.
  always_ff @(posedge clk) begin
    if (acc && cnt_r < CNT_W'(HDR_BYTES)) hdr_r[cnt_r[HDR_W-1:0]] <= in_data_byte;
  end

  assign pay.count  = cnt_r;
  assign pay.ovf    = ovf_r;
  assign pay.hot_x  = {hdr_r[0], hdr_r[1], hdr_r[2], hdr_r[3]};
  assign pay.hot_y  = {hdr_r[4], hdr_r[5], hdr_r[6], hdr_r[7]};
  assign pay.width  = {hdr_r[8], hdr_r[9], hdr_r[10], hdr_r[11]};
  assign pay.height = {hdr_r[12], hdr_r[13], hdr_r[14], hdr_r[15]};

endmodule

[rtl/core/cil_rows.sv]
// Decode and row engine for the cursor image loader: format check, then
// per-row reads of the clear and set planes from the payload RAM and the
// output register. Depends on cil_pkg.
module cil_rows import cil_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  cil_pay_t           pay,
  input  logic [7:0]         ram_rdata,
  output logic [ADDR_W-1:0]  ram_raddr,
  output logic               idle,
  output logic               clear,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_row_index,
  output logic [31:0]        out_source_bits,
  output logic [31:0]        out_mask_bits,
  output logic [5:0]         out_cursor_width,
  output logic [5:0]         out_cursor_height,
  output logic signed [31:0] out_hot_x,
  output logic signed [31:0] out_hot_y,
  output logic [1:0]         out_format_used,
  output logic               out_final_row
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SETUP, S_READ, S_DRAIN, S_OUT
  } state_t;

  state_t state_r;

  // Check-stage results.
  logic              cond_r, zero_r, small_r;
  logic [19:0]       prod_r;
  logic [WB_W-1:0]   ws_r;
  logic [ROWS_W-1:0] hs_r;

  // Cursor being emitted.
  logic [1:0]        fmt_r;
  logic [31:0]       hx_r, hy_r;
  logic [WB_W-1:0]   w_r;
  logic [ROWS_W-1:0] h_r;
  logic [ADDR_W-1:0] bpl_r, clr_r, set_r;
  logic [4:0]        row_r;
  logic [2:0]        k_r;
  logic [7:0]        c_r;
  logic [31:0]       src_r, msk_r;
  logic              rd_vld_r, rd_set_r;
  logic [1:0]        rd_j_r;

  // Selection made at setup.
  logic [CNT_W-1:0]  nm16;
  logic              sized_ok, fixed_ok;
  logic [1:0]        sel_fmt;
  logic [WB_W-1:0]   sel_w;
  logic [ROWS_W-1:0] sel_h;
  logic [ADDR_W-1:0] sel_bpl, sel_clr, sel_set;
  logic [31:0]       sel_hx, sel_hy;
  logic [3:0]        last_k;
  logic              final_row;
  logic              pos_w;

  assign nm16     = pay.count - CNT_W'(HDR_BYTES);
  assign sized_ok = !pay.ovf && pay.count >= CNT_W'(HDR_BYTES) && cond_r &&
                    (zero_r ? pay.count == CNT_W'(HDR_BYTES)
                            : (small_r && prod_r == 20'(nm16)));
  assign fixed_ok = pay.ovf || pay.count >= CNT_W'(FIXED_MIN);
  assign pos_w    = !pay.width[31] && pay.width != 32'd0;

  always_comb begin
    sel_fmt = FMT_CLEAR;
    sel_w   = '0;
    sel_h   = '0;
    sel_bpl = bpl_r;
    sel_clr = '0;
    sel_set = '0;
    sel_hx  = '0;
    sel_hy  = '0;
    if (sized_ok) begin
      sel_fmt = FMT_SIZED;
      sel_w   = ws_r;
      sel_h   = hs_r;
      sel_clr = ADDR_W'(HDR_BYTES);
      sel_set = ADDR_W'(CNT_W'(HDR_BYTES) + (nm16 >> 1));
      sel_hx  = pay.hot_x;
      sel_hy  = pay.hot_y;
    end else if (fixed_ok) begin
      sel_fmt = FMT_FIXED;
      sel_w   = WB_W'(FIXED_BPL);
      sel_h   = ROWS_W'(FIXED_ROWS);
      sel_bpl = ADDR_W'(FIXED_BPL);
      sel_clr = ADDR_W'(FIXED_CLR);
      sel_set = ADDR_W'(FIXED_SET);
      sel_hx  = pay.hot_x;
      sel_hy  = pay.hot_y;
    end
  end

  // Reads alternate clear byte then set byte for each visible byte of the row.
  assign ram_raddr = (k_r[0] ? set_r : clr_r) + ADDR_W'(k_r[2:1]);
  assign last_k    = {1'b0, w_r} * 4'd2 - 4'd1;
  assign final_row = (h_r == '0) || (ROWS_W'(row_r) + ROWS_W'(1) == h_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == S_READ);
      unique case (state_r)
        S_IDLE:  if (start) state_r <= S_CHECK;
        S_CHECK: state_r <= S_SETUP;
        S_SETUP: state_r <= (sel_h == '0 || sel_w == '0) ? S_OUT : S_READ;
        S_READ:  if ({1'b0, k_r} == last_k) state_r <= S_DRAIN;
        S_DRAIN: state_r <= S_OUT;
        S_OUT: begin
          if (out_ready) begin
            if (final_row)       state_r <= S_IDLE;
            else if (w_r == '0)  state_r <= S_OUT;
            else                 state_r <= S_READ;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    rd_set_r <= k_r[0];
    rd_j_r   <= k_r[2:1];
    case (state_r)
      S_CHECK: begin
        cond_r  <= pay.width[2:0] == 3'd0 && !pay.height[0] && !pay.height[31];
        zero_r  <= pay.width == 32'd0 || pay.height == 32'd0;
        small_r <= !pay.width[31] && pay.width[31:13] == '0 && pay.height[31:10] == '0;
        prod_r  <= 20'(pay.width[12:3]) * 20'(pay.height[9:0]);
        bpl_r   <= ADDR_W'(pay.width[12:3]);
        if (!pos_w)                          ws_r <= '0;
        else if (pay.width[31:3] > 29'(ROW_BYTES)) ws_r <= WB_W'(ROW_BYTES);
        else                                 ws_r <= WB_W'(pay.width[5:3]);
        if (pay.height[31:6] != '0) hs_r <= ROWS_W'(CURSOR_SIZE);
        else                        hs_r <= ROWS_W'(pay.height[5:1]);
      end
      S_SETUP: begin
        fmt_r <= sel_fmt;
        w_r   <= sel_w;
        h_r   <= sel_h;
        bpl_r <= sel_bpl;
        clr_r <= sel_clr;
        set_r <= sel_set;
        hx_r  <= sel_hx;
        hy_r  <= sel_hy;
        row_r <= '0;
        k_r   <= '0;
        src_r <= '0;
        msk_r <= '0;
      end
      S_READ: k_r <= k_r + 3'd1;
      S_OUT: begin
        if (out_ready && !final_row) begin
          row_r <= row_r + 5'd1;
          clr_r <= clr_r + bpl_r;
          set_r <= set_r + bpl_r;
          k_r   <= '0;
          src_r <= '0;
          msk_r <= '0;
        end
      end
      default: ;
    endcase
    if (rd_vld_r) begin
      if (!rd_set_r) begin
        c_r <= ram_rdata;
      end else begin
        src_r[{rd_j_r, 3'b000} +: 8] <= rev8(ram_rdata);
        msk_r[{rd_j_r, 3'b000} +: 8] <= rev8(ram_rdata | c_r);
      end
    end
  end

  assign idle              = state_r == S_IDLE;
  assign clear             = state_r == S_SETUP;
  assign out_valid         = state_r == S_OUT;
  assign out_row_index     = row_r;
  assign out_source_bits   = src_r;
  assign out_mask_bits     = msk_r;
  assign out_cursor_width  = {w_r, 3'b000};
  assign out_cursor_height = h_r;
  assign out_hot_x         = hx_r;
  assign out_hot_y         = hy_r;
  assign out_format_used   = fmt_r;
  assign out_final_row     = final_row;

endmodule

[rtl/core/cil_checker.sv]
// Port-level checks for the cursor image loader, bound to the top level.
// Depends on the cursor_image_loader port list.
module cil_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         in_data_byte,
  input logic               in_last_byte,
  input logic               out_valid,
  input logic               out_ready,
  input logic [4:0]         out_row_index,
  input logic [31:0]        out_source_bits,
  input logic [31:0]        out_mask_bits,
  input logic [5:0]         out_cursor_width,
  input logic [5:0]         out_cursor_height,
  input logic signed [31:0] out_hot_x,
  input logic signed [31:0] out_hot_y,
  input logic [1:0]         out_format_used,
  input logic               out_final_row
);

  // A stalled result keeps its row and bits.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index) &&
      $stable(out_source_bits) && $stable(out_mask_bits))
    else $error("stalled result changed");

  // Intake and result emission never overlap.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is shown");

  // A cleared cursor is a single empty row.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_format_used == 2'd0 |->
      out_cursor_height == 6'd0 && out_row_index == 5'd0 && out_final_row &&
      out_mask_bits == 32'd0)
    else $error("cleared cursor result malformed");

  // A row that is not the last one lies below the cursor height.
  a_rows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_row |->
      ({1'b0, out_row_index} + 6'd1) < out_cursor_height)
    else $error("non-final row at or past cursor height");

  // Intake reopens right after the final row is transferred.
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_final_row |=> in_ready)
    else $error("intake not reopened after final row");

endmodule

bind cursor_image_loader cil_checker u_cil_checker (.*);
